FILE: sv/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg - shared constants and types for the PLL FM demodulator
// Widths, CORDIC angle table, register indexes, reset values and the
// configuration bundle passed from the top level to the loop filter.
// ----------------------------------------------------------------------------
package pfd_pkg;

    // Sizing
    localparam int SAMPLE_WIDTH  = 16;
    localparam int PHASE_WIDTH   = 32;
    localparam int CORDIC_STAGES = 18;

    localparam int GUARD_SHIFT     = 40 - SAMPLE_WIDTH;
    localparam int CORDIC_WIDTH    = SAMPLE_WIDTH + GUARD_SHIFT + 3;
    localparam int ANGLE_WIDTH     = 34;
    localparam int PHASE_SHIFT     = 32 - PHASE_WIDTH;
    localparam int STEP_WIDTH      = $clog2(CORDIC_STAGES);
    localparam int AUDIO_WIDTH     = 16;
    localparam int FREQ_WIDTH      = 32;
    localparam int DC_WIDTH        = 56;
    localparam int COEF_WIDTH      = 24;
    localparam int LIMIT_WIDTH     = 31;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 31;

    // Multiplier: unsigned coefficient times a signed operand
    localparam int MUL_B_WIDTH = 33;
    localparam int PROD_WIDTH  = COEF_WIDTH + 1 + MUL_B_WIDTH;

    // atan(2^-k), 2^32 is one full turn
    localparam logic [31:0] ATAN_TABLE [30] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1
    };

    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // Register reset values
    localparam logic [COEF_WIDTH-1:0]  LOOP_ALPHA_RST = 24'd7763290;
    localparam logic [COEF_WIDTH-1:0]  LOOP_BETA_RST  = 24'd1796700;
    localparam logic [LIMIT_WIDTH-1:0] FREQ_LIMIT_RST = 31'd1342177280;
    localparam logic [COEF_WIDTH-1:0]  DC_COEF_RST    = 24'd173860;
    localparam logic [COEF_WIDTH-1:0]  OUT_SCALE_RST  = 24'd83885;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_LOOP_ALPHA = 3'd0,
        CFG_LOOP_BETA  = 3'd1,
        CFG_FREQ_LIMIT = 3'd2,
        CFG_DC_COEF    = 3'd3,
        CFG_OUT_SCALE  = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [COEF_WIDTH-1:0]  loop_alpha;
        logic [COEF_WIDTH-1:0]  loop_beta;
        logic [LIMIT_WIDTH-1:0] freq_limit;
        logic [COEF_WIDTH-1:0]  dc_coef;
        logic [COEF_WIDTH-1:0]  out_scale;
    } t_cfg;

endpackage

FILE: sv/pfd_cordic.sv
// ----------------------------------------------------------------------------
// pfd_cordic - iterative CORDIC phase detector
// Rotates the sample by the NCO phase, then vectors the product to get its
// angle. One shared add/shift stage runs one iteration per cycle for both.
// ----------------------------------------------------------------------------
module pfd_cordic (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [pfd_pkg::SAMPLE_WIDTH-1:0] i_x,
    input  logic signed [pfd_pkg::SAMPLE_WIDTH-1:0] i_y,
    input  logic        [pfd_pkg::PHASE_WIDTH-1:0]  i_phase,
    output logic                                   o_done,
    output logic signed [pfd_pkg::PHASE_WIDTH-1:0]  o_err
);

    typedef enum logic [2:0] {
        C_IDLE,
        C_ROT,
        C_VPRE,
        C_VEC,
        C_FIN
    } t_state;

    t_state                                     r_state;
    logic signed [pfd_pkg::CORDIC_WIDTH-1:0]    r_x;
    logic signed [pfd_pkg::CORDIC_WIDTH-1:0]    r_y;
    logic signed [pfd_pkg::ANGLE_WIDTH-1:0]     r_z;
    logic        [pfd_pkg::STEP_WIDTH-1:0]      r_k;
    logic                                       r_done;
    logic signed [pfd_pkg::PHASE_WIDTH-1:0]     r_err;

    logic signed [pfd_pkg::CORDIC_WIDTH-1:0]    x0;
    logic signed [pfd_pkg::CORDIC_WIDTH-1:0]    y0;
    logic        [31:0]                         ang;
    logic signed [pfd_pkg::CORDIC_WIDTH-1:0]    qx;
    logic signed [pfd_pkg::CORDIC_WIDTH-1:0]    qy;
    logic signed [pfd_pkg::CORDIC_WIDTH-1:0]    dx;
    logic signed [pfd_pkg::CORDIC_WIDTH-1:0]    dy;
    logic signed [pfd_pkg::ANGLE_WIDTH-1:0]     atan_z;
    logic signed [pfd_pkg::ANGLE_WIDTH-1:0]     quarter;
    logic                                       rot_pos;
    logic signed [pfd_pkg::CORDIC_WIDTH-1:0]    step_x;
    logic signed [pfd_pkg::CORDIC_WIDTH-1:0]    step_y;
    logic signed [pfd_pkg::ANGLE_WIDTH-1:0]     step_z;
    logic signed [pfd_pkg::CORDIC_WIDTH-1:0]    vx;
    logic signed [pfd_pkg::CORDIC_WIDTH-1:0]    vy;
    logic signed [pfd_pkg::ANGLE_WIDTH-1:0]     vz;
    logic signed [pfd_pkg::ANGLE_WIDTH-1:0]     neg_z;
    logic signed [31:0]                         e32;
    logic signed [pfd_pkg::PHASE_WIDTH-1:0]     err;
    logic                                       last;
    logic                                       zero_vec;

    always_comb begin
        x0  = pfd_pkg::CORDIC_WIDTH'(i_x) <<< pfd_pkg::GUARD_SHIFT;
        y0  = pfd_pkg::CORDIC_WIDTH'(i_y) <<< pfd_pkg::GUARD_SHIFT;
        ang = 32'(i_phase) << pfd_pkg::PHASE_SHIFT;

        // coarse quarter-turn rotation from the two top phase bits
        unique case (ang[31:30])
            2'd1: begin
                qx = -y0;
                qy = x0;
            end
            2'd2: begin
                qx = -x0;
                qy = -y0;
            end
            2'd3: begin
                qx = y0;
                qy = -x0;
            end
            default: begin
                qx = x0;
                qy = y0;
            end
        endcase

        dx      = r_y >>> r_k;
        dy      = r_x >>> r_k;
        atan_z  = pfd_pkg::ANGLE_WIDTH'(pfd_pkg::ATAN_TABLE[r_k]);
        quarter = pfd_pkg::ANGLE_WIDTH'(pfd_pkg::QUARTER_TURN);

        // rotation drives z to zero, vectoring drives y to zero
        rot_pos = (r_state == C_ROT) ? !r_z[pfd_pkg::ANGLE_WIDTH-1] : !(r_y > 0);
        step_x  = rot_pos ? r_x - dx : r_x + dx;
        step_y  = rot_pos ? r_y + dy : r_y - dy;
        step_z  = rot_pos ? r_z - atan_z : r_z + atan_z;

        // fold the left half-plane into the right before vectoring
        if (r_x[pfd_pkg::CORDIC_WIDTH-1]) begin
            if (!r_y[pfd_pkg::CORDIC_WIDTH-1]) begin
                vx = r_y;
                vy = -r_x;
                vz = quarter;
            end else begin
                vx = -r_y;
                vy = r_x;
                vz = -quarter;
            end
        end else begin
            vx = r_x;
            vy = r_y;
            vz = '0;
        end

        neg_z    = -r_z;
        e32      = neg_z[31:0];
        err      = pfd_pkg::PHASE_WIDTH'(e32 >>> pfd_pkg::PHASE_SHIFT);
        last     = (r_k == pfd_pkg::STEP_WIDTH'(pfd_pkg::CORDIC_STAGES - 1));
        zero_vec = (r_x == '0) && (r_y == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_k     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_x     <= qx;
                        r_y     <= qy;
                        r_z     <= pfd_pkg::ANGLE_WIDTH'(ang[29:0]);
                        r_k     <= '0;
                        r_state <= C_ROT;
                    end
                end
                C_ROT: begin
                    r_x <= step_x;
                    r_y <= step_y;
                    r_z <= step_z;
                    if (last) begin
                        r_k     <= '0;
                        r_state <= C_VPRE;
                    end else begin
                        r_k <= pfd_pkg::STEP_WIDTH'(r_k + 1'b1);
                    end
                end
                C_VPRE: begin
                    // a zero vector has no angle: report zero error
                    if (zero_vec) begin
                        r_z     <= '0;
                        r_state <= C_FIN;
                    end else begin
                        r_x     <= vx;
                        r_y     <= vy;
                        r_z     <= vz;
                        r_state <= C_VEC;
                    end
                end
                C_VEC: begin
                    r_x <= step_x;
                    r_y <= step_y;
                    r_z <= step_z;
                    if (last) begin
                        r_state <= C_FIN;
                    end else begin
                        r_k <= pfd_pkg::STEP_WIDTH'(r_k + 1'b1);
                    end
                end
                C_FIN: begin
                    r_err   <= err;
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_err  = r_err;

endmodule

FILE: sv/pfd_loop.sv
// ----------------------------------------------------------------------------
// pfd_loop - second-order loop filter, NCO and DC removal
// A small sequencer steps one registered multiplier through the five
// products of the loop update, the DC low-pass and the output scaling.
// ----------------------------------------------------------------------------
module pfd_loop (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [pfd_pkg::PHASE_WIDTH-1:0]  i_err,
    input  pfd_pkg::t_cfg                          i_cfg,
    output logic        [pfd_pkg::PHASE_WIDTH-1:0]  o_phase,
    output logic                                   o_done,
    output logic signed [pfd_pkg::AUDIO_WIDTH-1:0]  o_audio
);

    typedef enum logic [3:0] {
        L_IDLE,
        L_MUL_BETA,
        L_MUL_ALPHA,
        L_PHASE,
        L_MUL_HI,
        L_MUL_LO,
        L_DC,
        L_MUL_OUT,
        L_OUT
    } t_state;

    localparam int FW = pfd_pkg::FREQ_WIDTH;
    localparam int PW = pfd_pkg::PROD_WIDTH;
    localparam int BW = pfd_pkg::MUL_B_WIDTH;
    localparam int DW = pfd_pkg::DC_WIDTH;

    t_state                                     r_state;
    logic signed [pfd_pkg::PHASE_WIDTH-1:0]     r_err;
    logic        [pfd_pkg::PHASE_WIDTH-1:0]     r_phase;
    logic signed [FW-1:0]                       r_freq;
    logic signed [DW-1:0]                       r_dc;
    logic signed [DW:0]                         r_diff;
    logic signed [PW-1:0]                       r_acc;
    logic signed [PW-1:0]                       r_prod;
    logic                                       r_done;
    logic signed [pfd_pkg::AUDIO_WIDTH-1:0]     r_audio;

    logic        [pfd_pkg::COEF_WIDTH-1:0]      mul_a;
    logic signed [BW-1:0]                       mul_b;
    logic signed [PW-1:0]                       n_prod;
    logic signed [BW-1:0]                       prod_s24;
    logic signed [FW+1:0]                       f_raw;
    logic signed [FW+1:0]                       lim;
    logic signed [FW-1:0]                       f_clamp;
    logic signed [PW-1:0]                       diff_full;
    logic signed [BW-1:0]                       diff_hi;
    logic signed [BW-1:0]                       diff_lo;
    logic signed [BW-1:0]                       out_diff;
    logic signed [PW-1:0]                       out_full;
    logic signed [pfd_pkg::AUDIO_WIDTH-1:0]     out_sat;

    always_comb begin
        prod_s24 = BW'(r_prod >>> 24);

        f_raw = (FW+2)'(r_freq) + (FW+2)'(prod_s24);
        lim   = (FW+2)'({1'b0, i_cfg.freq_limit});
        if (f_raw > lim) begin
            f_clamp = FW'(lim);
        end else if (f_raw < -lim) begin
            f_clamp = FW'(-lim);
        end else begin
            f_clamp = FW'(f_raw);
        end

        diff_full = (PW'(r_freq) <<< 24) - PW'(r_dc);
        diff_hi   = BW'(r_diff >>> 24);
        diff_lo   = $signed(BW'(r_diff[23:0]));
        out_diff  = BW'(r_freq) - BW'(r_dc >>> 24);

        out_full = r_prod >>> 32;
        if (out_full > PW'(32767)) begin
            out_sat = 16'sd32767;
        end else if (out_full < -PW'(32768)) begin
            out_sat = -16'sd32768;
        end else begin
            out_sat = pfd_pkg::AUDIO_WIDTH'(out_full);
        end

        // operand select for the shared multiplier
        case (r_state)
            L_MUL_BETA: begin
                mul_a = i_cfg.loop_beta;
                mul_b = BW'(r_err);
            end
            L_MUL_ALPHA: begin
                mul_a = i_cfg.loop_alpha;
                mul_b = BW'(r_err);
            end
            L_MUL_HI: begin
                mul_a = i_cfg.dc_coef;
                mul_b = diff_hi;
            end
            L_MUL_LO: begin
                mul_a = i_cfg.dc_coef;
                mul_b = diff_lo;
            end
            L_MUL_OUT: begin
                mul_a = i_cfg.out_scale;
                mul_b = out_diff;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        n_prod = PW'($signed({1'b0, mul_a}) * mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_phase <= '0;
            r_freq  <= '0;
            r_dc    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_prod <= n_prod;
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_err   <= i_err;
                        r_state <= L_MUL_BETA;
                    end
                end
                L_MUL_BETA: begin
                    r_state <= L_MUL_ALPHA;
                end
                L_MUL_ALPHA: begin
                    r_freq  <= f_clamp;
                    r_state <= L_PHASE;
                end
                L_PHASE: begin
                    r_phase <= r_phase + pfd_pkg::PHASE_WIDTH'(r_freq)
                               + pfd_pkg::PHASE_WIDTH'(prod_s24);
                    r_diff  <= (DW+1)'(diff_full);
                    r_state <= L_MUL_HI;
                end
                L_MUL_HI: begin
                    r_state <= L_MUL_LO;
                end
                L_MUL_LO: begin
                    r_acc   <= PW'(r_dc) + r_prod;
                    r_state <= L_DC;
                end
                L_DC: begin
                    r_dc    <= DW'(r_acc + (r_prod >>> 24));
                    r_state <= L_MUL_OUT;
                end
                L_MUL_OUT: begin
                    r_state <= L_OUT;
                end
                L_OUT: begin
                    r_audio <= out_sat;
                    r_done  <= 1'b1;
                    r_state <= L_IDLE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_phase = r_phase;
    assign o_done  = r_done;
    assign o_audio = r_audio;

endmodule

FILE: sv/pll_fm_demodulator.sv
// ----------------------------------------------------------------------------
// pll_fm_demodulator - PLL FM demodulator with DC removal
// Channels:
//   channel   handshake           payload
//   input     i_valid / o_stall   i_sample_i, i_sample_q, i_block_end
//   output    o_valid / i_stall   o_audio, o_block_end_out
//   config    i_cfg_we            i_cfg_index, i_cfg_data
// One item occupies the core through rotation and vectoring, one CORDIC
// iteration per cycle for CORDIC_STAGES iterations each, then eight steps
// of the shared loop multiplier. o_stall stays high meanwhile.
// Reset is synchronous, active low, and restores registers and loop state.
// A result waits in the output register; a held result stalls the core.
// ----------------------------------------------------------------------------
module pll_fm_demodulator (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_we,
    input  logic [pfd_pkg::CFG_INDEX_WIDTH-1:0]         i_cfg_index,
    input  logic [pfd_pkg::CFG_DATA_WIDTH-1:0]          i_cfg_data,
    input  logic                                        i_valid,
    output logic                                        o_stall,
    input  logic signed [pfd_pkg::SAMPLE_WIDTH-1:0]     i_sample_i,
    input  logic signed [pfd_pkg::SAMPLE_WIDTH-1:0]     i_sample_q,
    input  logic                                        i_block_end,
    output logic                                        o_valid,
    input  logic                                        i_stall,
    output logic signed [pfd_pkg::AUDIO_WIDTH-1:0]      o_audio,
    output logic                                        o_block_end_out
);

    typedef enum logic [1:0] {
        T_IDLE,
        T_CORDIC,
        T_LOOP,
        T_HOLD
    } t_state;

    t_state                                     r_state;
    pfd_pkg::t_cfg                              r_cfg;
    logic                                       r_block_end;
    logic                                       r_out_valid;
    logic signed [pfd_pkg::AUDIO_WIDTH-1:0]     r_out_audio;
    logic                                       r_out_block_end;

    logic                                       in_accept;
    logic                                       out_free;
    logic                                       load_out;
    logic                                       cordic_done;
    logic signed [pfd_pkg::PHASE_WIDTH-1:0]     cordic_err;
    logic        [pfd_pkg::PHASE_WIDTH-1:0]     loop_phase;
    logic                                       loop_done;
    logic signed [pfd_pkg::AUDIO_WIDTH-1:0]     loop_audio;

    pfd_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept),
        .i_x     (i_sample_i),
        .i_y     (i_sample_q),
        .i_phase (loop_phase),
        .o_done  (cordic_done),
        .o_err   (cordic_err)
    );

    pfd_loop u_loop (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_done),
        .i_err   (cordic_err),
        .i_cfg   (r_cfg),
        .o_phase (loop_phase),
        .o_done  (loop_done),
        .o_audio (loop_audio)
    );

    assign o_stall   = (r_state != T_IDLE);
    assign in_accept = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign load_out  = ((r_state == T_LOOP && loop_done) || r_state == T_HOLD) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                T_IDLE: begin
                    if (in_accept) begin
                        r_block_end <= i_block_end;
                        r_state     <= T_CORDIC;
                    end
                end
                T_CORDIC: begin
                    if (cordic_done) begin
                        r_state <= T_LOOP;
                    end
                end
                T_LOOP: begin
                    if (loop_done) begin
                        r_state <= out_free ? T_IDLE : T_HOLD;
                    end
                end
                T_HOLD: begin
                    // hold the finished item until the output slot drains
                    if (out_free) begin
                        r_state <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase

            if (load_out) begin
                r_out_valid     <= 1'b1;
                r_out_audio     <= loop_audio;
                r_out_block_end <= r_block_end;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loop_alpha <= pfd_pkg::LOOP_ALPHA_RST;
            r_cfg.loop_beta  <= pfd_pkg::LOOP_BETA_RST;
            r_cfg.freq_limit <= pfd_pkg::FREQ_LIMIT_RST;
            r_cfg.dc_coef    <= pfd_pkg::DC_COEF_RST;
            r_cfg.out_scale  <= pfd_pkg::OUT_SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (pfd_pkg::t_cfg_index'(i_cfg_index))
                pfd_pkg::CFG_LOOP_ALPHA: r_cfg.loop_alpha <= pfd_pkg::COEF_WIDTH'(i_cfg_data);
                pfd_pkg::CFG_LOOP_BETA:  r_cfg.loop_beta  <= pfd_pkg::COEF_WIDTH'(i_cfg_data);
                pfd_pkg::CFG_FREQ_LIMIT: r_cfg.freq_limit <= pfd_pkg::LIMIT_WIDTH'(i_cfg_data);
                pfd_pkg::CFG_DC_COEF:    r_cfg.dc_coef    <= pfd_pkg::COEF_WIDTH'(i_cfg_data);
                pfd_pkg::CFG_OUT_SCALE:  r_cfg.out_scale  <= pfd_pkg::COEF_WIDTH'(i_cfg_data);
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_audio         = r_out_audio;
    assign o_block_end_out = r_out_block_end;

endmodule

FILE: sv/pfd_checker.sv
// ----------------------------------------------------------------------------
// pfd_checker - port-level checks for the PLL FM demodulator
// Watches the top-level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module pfd_checker (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    input  logic                                        o_stall,
    input  logic                                        o_valid,
    input  logic                                        i_stall,
    input  logic signed [pfd_pkg::AUDIO_WIDTH-1:0]      o_audio,
    input  logic                                        o_block_end_out
);

    // a stalled result stays offered
    a_out_valid_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid
    ) else $error("output item dropped while stalled");

    // a stalled result keeps its payload
    a_out_payload_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_audio) && $stable(o_block_end_out)
    ) else $error("output payload changed while stalled");

    // the core turns busy right after it takes an item
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall
    ) else $error("input taken again without processing time");

    // a new result only appears at the end of a busy period
    a_result_from_work: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall)
    ) else $error("output item appeared without an item in work");

endmodule

bind pll_fm_demodulator pfd_checker u_pfd_checker (.*);
